@@ src/ipsd_pkg.sv @@
// Package with the shared types, widths, constants and helper functions of the detector.
package ipsd_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int FIELD_W      = 32;
    localparam int LEN_W        = 17;
    localparam int RATE_W       = 16;
    localparam int LIM_W        = LEN_W + RATE_W;
    localparam int SUM_W        = 48;
    localparam int CNT_W        = 32;
    localparam int POS_W        = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [LEN_W-1:0]  MAX_WINDOW         = LEN_W'(65536);
    localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST  = LEN_W'(1);
    localparam logic [RATE_W-1:0] REF_RATE_RST       = RATE_W'(500);
    localparam logic [RATE_W-1:0] BRANCH_RATE_RST    = RATE_W'(200);
    localparam logic [POS_W-1:0]  TOTAL_SAMPLES_RST  = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH     = 2'd0,
        REG_REF_NOISE_RATE    = 2'd1,
        REG_BRANCH_NOISE_RATE = 2'd2,
        REG_TOTAL_SAMPLES     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_CALIBRATING = 2'd0,
        MODE_MEASURING   = 2'd1,
        MODE_DONE        = 2'd2
    } mode_t;

    // Settings as the datapath sees them: clamped length and precomputed limits.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] total;
        logic [LIM_W-1:0] ref_lim;
        logic [LIM_W-1:0] branch_lim;
    } cfg_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = LEN_W'(1);
        end
        else if (v > MAX_WINDOW) begin
            r = MAX_WINDOW;
        end
        return r;
    endfunction

endpackage

@@ src/ipsd_if.sv @@
// Valid/ready channel interfaces for the sample input and the window result output.
interface ipsd_sample_if
    import ipsd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] ref_count;
    logic [FIELD_W-1:0] branch_count;

    modport source (output valid, output ref_count, output branch_count, input ready);
    modport sink   (input valid, input ref_count, input branch_count, output ready);
endinterface

interface ipsd_result_if
    import ipsd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             unstable;
    logic [CNT_W-1:0] stable_windows;
    logic [CNT_W-1:0] unstable_windows;
    logic [CNT_W-1:0] calibrations;

    modport source (output valid, output unstable, output stable_windows,
                    output unstable_windows, output calibrations, input ready);
    modport sink   (input valid, input unstable, input stable_windows,
                    input unstable_windows, input calibrations, output ready);
endinterface

@@ src/ipsd_cfg_regs.sv @@
// Configuration registers with the clamped window length and the two deviation limits.
module ipsd_cfg_regs
    import ipsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [LEN_W-1:0]  window_length_reg, window_length_next;
    logic [RATE_W-1:0] ref_rate_reg, ref_rate_next;
    logic [RATE_W-1:0] branch_rate_reg, branch_rate_next;
    logic [POS_W-1:0]  total_reg, total_next;
    cfg_t              cfg_reg, cfg_next;

    always_comb
    begin
        window_length_next = window_length_reg;
        ref_rate_next      = ref_rate_reg;
        branch_rate_next   = branch_rate_reg;
        total_next         = total_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_WINDOW_LENGTH:     window_length_next = cfg_data[LEN_W-1:0];
                REG_REF_NOISE_RATE:    ref_rate_next      = cfg_data[RATE_W-1:0];
                REG_BRANCH_NOISE_RATE: branch_rate_next   = cfg_data[RATE_W-1:0];
                REG_TOTAL_SAMPLES:     total_next         = cfg_data[POS_W-1:0];
            endcase
        end
        // The limits follow the new values in the same edge as the write.
        cfg_next.len        = eff_len(window_length_next);
        cfg_next.total      = total_next;
        cfg_next.ref_lim    = LIM_W'(cfg_next.len) * LIM_W'(ref_rate_next);
        cfg_next.branch_lim = LIM_W'(cfg_next.len) * LIM_W'(branch_rate_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg  <= WINDOW_LENGTH_RST;
            ref_rate_reg       <= REF_RATE_RST;
            branch_rate_reg    <= BRANCH_RATE_RST;
            total_reg          <= TOTAL_SAMPLES_RST;
            cfg_reg.len        <= WINDOW_LENGTH_RST;
            cfg_reg.total      <= TOTAL_SAMPLES_RST;
            cfg_reg.ref_lim    <= LIM_W'(REF_RATE_RST);
            cfg_reg.branch_lim <= LIM_W'(BRANCH_RATE_RST);
        end
        else
        begin
            window_length_reg <= window_length_next;
            ref_rate_reg      <= ref_rate_next;
            branch_rate_reg   <= branch_rate_next;
            total_reg         <= total_next;
            cfg_reg           <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/ipsd_core.sv @@
// Sample input register, window accumulation, stability verdict and result register.
module ipsd_core
    import ipsd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    ipsd_sample_if.sink   sample,
    ipsd_result_if.source result
);

    // Input stage.
    logic                    in_valid_reg;
    logic [SAMPLE_WIDTH-1:0] in_ref_reg;
    logic [SAMPLE_WIDTH-1:0] in_branch_reg;

    // Window state.
    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg;
    logic [LEN_W-1:0] offset_reg;
    logic [SUM_W-1:0] ref_ref_reg, ref_branch_reg;
    logic [SUM_W-1:0] cur_ref_reg, cur_branch_reg;
    logic [CNT_W-1:0] stable_cnt_reg, unstable_cnt_reg, calib_cnt_reg;
    logic [CNT_W-1:0] stable_cnt_next, unstable_cnt_next, calib_cnt_next;

    // Result stage.
    logic             out_valid_reg;
    logic             out_unstable_reg;
    logic [CNT_W-1:0] out_stable_reg, out_unstable_cnt_reg, out_calib_reg;

    logic             process;
    logic             last;
    logic             end_hit;
    logic             accumulate;
    logic             take_ref;
    logic             emit;
    logic             bad;
    logic [SUM_W-1:0] sum_ref, sum_branch;
    logic [SUM_W-1:0] diff_ref, diff_branch;

    assign process      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || process;

    // Datapath for the item held in the input register.
    always_comb
    begin
        logic [SUM_W-1:0] base_ref;
        logic [SUM_W-1:0] base_branch;
        base_ref    = (offset_reg == '0) ? '0 : cur_ref_reg;
        base_branch = (offset_reg == '0) ? '0 : cur_branch_reg;
        sum_ref     = base_ref + SUM_W'(in_ref_reg);
        sum_branch  = base_branch + SUM_W'(in_branch_reg);
        diff_ref    = (sum_ref > ref_ref_reg) ? sum_ref - ref_ref_reg : ref_ref_reg - sum_ref;
        diff_branch = (sum_branch > ref_branch_reg) ? sum_branch - ref_branch_reg
                                                    : ref_branch_reg - sum_branch;
        bad  = (diff_ref > SUM_W'(cfg.ref_lim)) || (diff_branch > SUM_W'(cfg.branch_lim));
        last = ({1'b0, offset_reg} + (LEN_W+1)'(1)) >= {1'b0, cfg.len};
        // A new window is measured only while it and one more fit before the trace end.
        end_hit = (offset_reg == '0) && (mode_reg == MODE_MEASURING) &&
                  (({2'b0, pos_reg} + {{(POS_W+1-LEN_W){1'b0}}, cfg.len, 1'b0})
                   >= {2'b0, cfg.total});
    end

    // Mode sequencing.
    always_comb
    begin
        mode_next = mode_reg;
        if (process)
        begin
            unique case (mode_reg)
                MODE_CALIBRATING:
                begin
                    if (last)
                    begin
                        mode_next = MODE_MEASURING;
                    end
                end
                MODE_MEASURING:
                begin
                    if (end_hit)
                    begin
                        mode_next = MODE_DONE;
                    end
                    else if (last && bad)
                    begin
                        mode_next = MODE_CALIBRATING;
                    end
                end
                MODE_DONE: mode_next = MODE_DONE;
                default:   mode_next = MODE_DONE;
            endcase
        end
    end

    // Control decodes and counter updates.
    always_comb
    begin
        accumulate = process && ((mode_reg == MODE_CALIBRATING) ||
                                 ((mode_reg == MODE_MEASURING) && !end_hit));
        take_ref   = accumulate && last && (mode_reg == MODE_CALIBRATING);
        emit       = accumulate && last && (mode_reg == MODE_MEASURING);
        stable_cnt_next   = stable_cnt_reg;
        unstable_cnt_next = unstable_cnt_reg;
        calib_cnt_next    = calib_cnt_reg;
        if (emit)
        begin
            if (bad)
            begin
                unstable_cnt_next = sat_inc(unstable_cnt_reg);
                calib_cnt_next    = sat_inc(calib_cnt_reg);
            end
            else
            begin
                stable_cnt_next = sat_inc(stable_cnt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            mode_reg         <= MODE_CALIBRATING;
            pos_reg          <= '0;
            offset_reg       <= '0;
            stable_cnt_reg   <= '0;
            unstable_cnt_reg <= '0;
            calib_cnt_reg    <= CNT_W'(1);
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            mode_reg         <= mode_next;
            stable_cnt_reg   <= stable_cnt_next;
            unstable_cnt_reg <= unstable_cnt_next;
            calib_cnt_reg    <= calib_cnt_next;
            if (process)
            begin
                pos_reg <= sat_inc(pos_reg);
            end
            if (accumulate)
            begin
                offset_reg <= last ? '0 : offset_reg + LEN_W'(1);
            end
        end
    end

    // Payload registers: every one is written before it is read.
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_ref_reg    <= sample.ref_count[SAMPLE_WIDTH-1:0];
            in_branch_reg <= sample.branch_count[SAMPLE_WIDTH-1:0];
        end
        if (accumulate)
        begin
            cur_ref_reg    <= sum_ref;
            cur_branch_reg <= sum_branch;
        end
        if (take_ref)
        begin
            ref_ref_reg    <= sum_ref;
            ref_branch_reg <= sum_branch;
        end
        if (emit)
        begin
            out_unstable_reg     <= bad;
            out_stable_reg       <= stable_cnt_next;
            out_unstable_cnt_reg <= unstable_cnt_next;
            out_calib_reg        <= calib_cnt_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.unstable         = out_unstable_reg;
    assign result.stable_windows   = out_stable_reg;
    assign result.unstable_windows = out_unstable_cnt_reg;
    assign result.calibrations     = out_calib_reg;

`ifndef NO_ASSERTIONS
    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DONE) |=> (mode_reg == MODE_DONE))
        else $error("detector left the done mode");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("verdict was not loaded into the result register");

    a_unstable_recalibrates: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && bad) |=> ((mode_reg == MODE_CALIBRATING) && (offset_reg == '0)))
        else $error("unstable window did not start a new reference window");

    a_calib_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        calib_cnt_reg != '0)
        else $error("calibration count dropped to zero");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !emit)
        else $error("pending result overwritten");
`endif

endmodule

@@ src/interval_phase_stability_detector_top.sv @@
// Top level of the interval phase stability detector.
//
// Samples arrive on the sample channel (ref_count, branch_count), one transfer
// per cycle at most. They are summed over windows of window_length samples;
// the first window and every window after an unstable one become the
// reference, and each other window is compared with the reference. At the last
// sample of each measured window one transfer leaves on the result channel
// with the verdict and the saturating stable, unstable and calibration counts.
// Once a window would start too close to total_samples, all later samples are
// taken and dropped until reset.
// Each sample passes the input register and each verdict the result register;
// throughput is one sample per cycle unless a waiting result blocks it, set
// by the combinational window add and compare. A result waits in its output
// register while the receiver stalls; the sample behind it is then held in
// the input register and the sample channel deasserts ready until the result
// is taken. The user must write configuration through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
// Reset restores the register defaults and starts calibrating.
module interval_phase_stability_detector_top
    import ipsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ipsd_sample_if.sink           sample,
    ipsd_result_if.source         result
);

    cfg_t cfg;

    ipsd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipsd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sample (sample),
        .result (result)
    );

endmodule

@@ tb/tb_interval_phase_stability_detector_top.sv @@
// Self-checking testbench for the interval phase stability detector top level.
module tb_interval_phase_stability_detector_top;
    import ipsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_WAIT     = 8;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1850;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic             unstable;
        logic [CNT_W-1:0] stable_n;
        logic [CNT_W-1:0] unstable_n;
        logic [CNT_W-1:0] calib_n;
    } verdict_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    // For a write row, a carries the register data; for a sample row, a and b are the counts.
    typedef struct packed {
        row_kind_t          kind;
        cfg_index_t         idx;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic               typed;
        verdict_t           want;
    } script_row_t;

    localparam verdict_t NO_VERDICT = '0;

    localparam script_row_t SCRIPT [27] = '{
        '{ROW_WRITE,  REG_TOTAL_SAMPLES,     32'hFFFFFFFF, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd1000, 32'd1000, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd1500, 32'd1200, 1'b1,
          '{1'b0, 32'd1, 32'd0, 32'd1}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd1501, 32'd1000, 1'b1,
          '{1'b1, 32'd1, 32'd1, 32'd2}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd0, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd0, 32'd201, 1'b1,
          '{1'b1, 32'd1, 32'd2, 32'd3}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{1'b0, 32'd2, 32'd2, 32'd3}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd0, 32'd0, 1'b1,
          '{1'b1, 32'd2, 32'd3, 32'd4}},
        '{ROW_WRITE,  REG_REF_NOISE_RATE,    32'd0, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_WRITE,  REG_BRANCH_NOISE_RATE, 32'd0, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd5, 32'd5, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd5, 32'd5, 1'b1,
          '{1'b0, 32'd3, 32'd3, 32'd4}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd5, 32'd6, 1'b1,
          '{1'b1, 32'd3, 32'd4, 32'd5}},
        '{ROW_WRITE,  REG_REF_NOISE_RATE,    32'd65535, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_WRITE,  REG_BRANCH_NOISE_RATE, 32'd65535, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_WRITE,  REG_WINDOW_LENGTH,     32'd0, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd0, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd65535, 32'd65535, 1'b1,
          '{1'b0, 32'd4, 32'd4, 32'd5}},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd65536, 32'd0, 1'b1,
          '{1'b1, 32'd4, 32'd5, 32'd6}},
        '{ROW_WRITE,  REG_WINDOW_LENGTH,     32'd3, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd7, 32'd9, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd11, 32'd13, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'h80000000, 32'h7FFFFFFF, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd1, 32'd2, 1'b0, NO_VERDICT},
        // Shortening the window while it is half full ends it at the next sample.
        '{ROW_WRITE,  REG_WINDOW_LENGTH,     32'd2, 32'd0, 1'b0, NO_VERDICT},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH,     32'd3, 32'd4, 1'b0, NO_VERDICT}
    };

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ipsd_sample_if sample_ch ();
    ipsd_result_if result_ch ();

    interval_phase_stability_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // Predictor copy of the registers and of the window state.
    logic [LEN_W-1:0]  cfg_len;
    logic [RATE_W-1:0] cfg_ref_rate;
    logic [RATE_W-1:0] cfg_br_rate;
    logic [POS_W-1:0]  cfg_total;
    logic [POS_W-1:0]  trace_pos;
    mode_t             phase_mode;
    logic [LEN_W-1:0]  win_off;
    logic [SUM_W-1:0]  base_ref_sum;
    logic [SUM_W-1:0]  base_br_sum;
    logic [SUM_W-1:0]  win_ref_sum;
    logic [SUM_W-1:0]  win_br_sum;
    logic [CNT_W-1:0]  n_stable;
    logic [CNT_W-1:0]  n_unstable;
    logic [CNT_W-1:0]  n_calib;

    verdict_t expected_verdicts [$];
    int       fault_count = 0;
    int       samples_fed;
    int       quiet = 0;
    int       hold_left = 0;
    int       hold_asked;
    int       hold_served = 0;
    bit       calm;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void predict_window(input logic [FIELD_W-1:0] r,
                                           input logic [FIELD_W-1:0] b,
                                           output bit got, output verdict_t v);
        logic [LEN_W-1:0] len;
        logic [63:0]      reach;
        logic [LIM_W-1:0] ref_lim;
        logic [LIM_W-1:0] br_lim;
        logic [SUM_W-1:0] ref_dev;
        logic [SUM_W-1:0] br_dev;
        bit               ignored;
        bit               bad;
        got = 1'b0;
        v = NO_VERDICT;
        if (cfg_len == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg_len > MAX_WINDOW)
        begin
            len = MAX_WINDOW;
        end
        else
        begin
            len = cfg_len;
        end
        ignored = (phase_mode != MODE_CALIBRATING && phase_mode != MODE_MEASURING);
        if (!ignored && win_off == '0)
        begin
            // The end rule is only applied where a measured window would start.
            reach = 64'(trace_pos) + 64'(len) * 2;
            if (phase_mode == MODE_MEASURING && reach >= 64'(cfg_total))
            begin
                ignored = 1'b1;
            end
            else
            begin
                win_ref_sum = '0;
                win_br_sum = '0;
            end
        end
        if (ignored)
        begin
            phase_mode = MODE_DONE;
        end
        else
        begin
            win_ref_sum = win_ref_sum + SUM_W'(r);
            win_br_sum = win_br_sum + SUM_W'(b);
            if (32'(win_off) + 1 >= 32'(len))
            begin
                win_off = '0;
                if (phase_mode == MODE_CALIBRATING)
                begin
                    base_ref_sum = win_ref_sum;
                    base_br_sum = win_br_sum;
                    phase_mode = MODE_MEASURING;
                end
                else
                begin
                    ref_lim = LIM_W'(len) * LIM_W'(cfg_ref_rate);
                    br_lim = LIM_W'(len) * LIM_W'(cfg_br_rate);
                    ref_dev = (win_ref_sum > base_ref_sum) ? win_ref_sum - base_ref_sum
                                                           : base_ref_sum - win_ref_sum;
                    br_dev = (win_br_sum > base_br_sum) ? win_br_sum - base_br_sum
                                                        : base_br_sum - win_br_sum;
                    bad = (br_dev > SUM_W'(br_lim)) || (ref_dev > SUM_W'(ref_lim));
                    if (bad)
                    begin
                        n_unstable = (n_unstable == '1) ? n_unstable : n_unstable + 1;
                        n_calib = (n_calib == '1) ? n_calib : n_calib + 1;
                        phase_mode = MODE_CALIBRATING;
                    end
                    else
                    begin
                        n_stable = (n_stable == '1) ? n_stable : n_stable + 1;
                    end
                    v = '{bad, n_stable, n_unstable, n_calib};
                    got = 1'b1;
                end
            end
            else
            begin
                win_off = win_off + LEN_W'(1);
            end
        end
        trace_pos = (trace_pos == '1) ? trace_pos : trace_pos + 1;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_level();
        logic [FIELD_W-1:0] lvl;
        if ($urandom_range(0, 99) < 50)
        begin
            lvl = $urandom_range(0, 100000);
        end
        else
        begin
            lvl = $urandom;
        end
        return lvl;
    endfunction

    task automatic send_sample(input logic [FIELD_W-1:0] r, input logic [FIELD_W-1:0] b,
                               input logic typed, input verdict_t want);
        bit       got;
        verdict_t v;
        while (!calm && $urandom_range(0, 99) < 28)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.ref_count <= r;
        sample_ch.branch_count <= b;
        @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready))
        begin
            @(posedge clk);
        end
        predict_window(r, b, got, v);
        if (typed)
        begin
            expected_verdicts.push_back(want);
        end
        else if (got)
        begin
            expected_verdicts.push_back(v);
        end
        samples_fed++;
    endtask

    // Lets every outstanding verdict come out and the pipeline settle.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_WINDOW_LENGTH:     cfg_len = data[LEN_W-1:0];
            REG_REF_NOISE_RATE:    cfg_ref_rate = data[RATE_W-1:0];
            REG_BRANCH_NOISE_RATE: cfg_br_rate = data[RATE_W-1:0];
            REG_TOTAL_SAMPLES:     cfg_total = data[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] len,
                              input logic [CFG_DATA_W-1:0] ref_rate,
                              input logic [CFG_DATA_W-1:0] br_rate);
        drain();
        write_reg(REG_WINDOW_LENGTH, len);
        write_reg(REG_REF_NOISE_RATE, ref_rate);
        write_reg(REG_BRANCH_NOISE_RATE, br_rate);
        cfg_we <= 1'b0;
    endtask

    // Samples sit around a level that jumps now and then at a window boundary, with
    // jitter of the order of the noise rates and a share of fully random samples.
    task automatic drive_phase(input int n_items);
        logic [FIELD_W-1:0] lvl_r;
        logic [FIELD_W-1:0] lvl_b;
        logic [FIELD_W-1:0] r;
        logic [FIELD_W-1:0] b;
        int unsigned        spread_r;
        int unsigned        spread_b;
        lvl_r = pick_level();
        lvl_b = pick_level();
        spread_r = 32'(cfg_ref_rate) + 1;
        spread_b = 32'(cfg_br_rate) + 1;
        for (int i = 0; i < n_items; i++)
        begin
            if (win_off == '0 && $urandom_range(0, 99) < 25)
            begin
                lvl_r = pick_level();
                lvl_b = pick_level();
            end
            if ($urandom_range(0, 99) < 12)
            begin
                r = $urandom;
                b = $urandom;
            end
            else
            begin
                r = lvl_r + $urandom_range(0, 2 * spread_r) - spread_r;
                b = lvl_b + $urandom_range(0, 2 * spread_b) - spread_b;
            end
            send_sample(r, b, 1'b0, NO_VERDICT);
        end
    endtask

    // Receiver: random stalls, a long hold-off on request, and none at all while calm.
    always @(posedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge clk)
    begin : verdict_check
        verdict_t seen;
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen = '{result_ch.unstable, result_ch.stable_windows,
                     result_ch.unstable_windows, result_ch.calibrations};
            if (expected_verdicts.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                begin
                    $display("unexpected verdict: unstable=%0d stable=%0d unstable_n=%0d cal=%0d",
                             seen.unstable, seen.stable_n, seen.unstable_n, seen.calib_n);
                end
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (seen.unstable != want.unstable || seen.stable_n != want.stable_n ||
                    seen.unstable_n != want.unstable_n || seen.calib_n != want.calib_n)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                    begin
                        $display("verdict mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.unstable, want.stable_n, want.unstable_n, want.calib_n,
                                 seen.unstable, seen.stable_n, seen.unstable_n, seen.calib_n);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   phase_no;
        int   random_start;
        int   pick;
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] ref_rate;
        logic [CFG_DATA_W-1:0] br_rate;

        cfg_len = WINDOW_LENGTH_RST;
        cfg_ref_rate = REF_RATE_RST;
        cfg_br_rate = BRANCH_RATE_RST;
        cfg_total = TOTAL_SAMPLES_RST;
        trace_pos = '0;
        phase_mode = MODE_CALIBRATING;
        win_off = '0;
        base_ref_sum = '0;
        base_br_sum = '0;
        win_ref_sum = '0;
        win_br_sum = '0;
        n_stable = '0;
        n_unstable = '0;
        n_calib = CNT_W'(1);
        samples_fed = 0;
        hold_asked = 0;
        calm = 1'b0;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.ref_count <= '0;
        sample_ch.branch_count <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset defaults of length and rates, both limits, a zero length,
        // saturated counts, and a window shortened while it is being filled.
        foreach (SCRIPT[k])
        begin
            if (SCRIPT[k].kind == ROW_WRITE)
            begin
                drain();
                write_reg(SCRIPT[k].idx, SCRIPT[k].a);
                cfg_we <= 1'b0;
            end
            else
            begin
                send_sample(SCRIPT[k].a, SCRIPT[k].b, SCRIPT[k].typed, SCRIPT[k].want);
            end
        end

        random_start = samples_fed;
        phase_no = 0;
        while (samples_fed - random_start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                len = $urandom_range(1, 3);
            end
            else if (pick < 80)
            begin
                len = $urandom_range(4, 12);
            end
            else if (pick < 95)
            begin
                len = $urandom_range(13, 64);
            end
            else
            begin
                len = '0;
            end
            pick = $urandom_range(0, 9);
            ref_rate = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd65535 : $urandom_range(0, 3000);
            pick = $urandom_range(0, 9);
            br_rate = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd65535 : $urandom_range(0, 3000);
            // One phase keeps the result channel blocked while samples keep coming.
            if (phase_no == 6)
            begin
                len = 32'd1;
            end
            set_config(len, ref_rate, br_rate);
            calm = (phase_no == 3);
            if (phase_no == 6)
            begin
                hold_asked <= hold_asked + 1;
            end
            drive_phase($urandom_range(80, 160));
            phase_no++;
        end
        calm = 1'b0;

        // Largest window: the length is clamped to its maximum of 65536, so a short
        // burst stays inside one window until the next length write closes it.
        set_config(32'h0001FFFF, 32'd2000, 32'd1000);
        drive_phase(40);

        // End of trace lands a few samples ahead; a later total must not revive it.
        set_config(32'd1, 32'd500, 32'd200);
        @(posedge clk);
        write_reg(REG_TOTAL_SAMPLES, trace_pos + 6);
        cfg_we <= 1'b0;
        drive_phase(12);
        drain();
        write_reg(REG_TOTAL_SAMPLES, 32'hFFFFFFFF);
        cfg_we <= 1'b0;
        drive_phase(10);

        drain();
        if (fault_count == 0 && expected_verdicts.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
